/* rtl/core/cmsa_pkg.sv */
package cmsa_pkg;

	localparam int MAX_CHANNELS_DEF = 1024;
	localparam int MAX_POLS_DEF = 4;
	localparam int SAMPLE_BITS_DEF = 16;

	localparam int SUM_W = 48;
	localparam int SQS_W = 64;
	localparam int CNT_W = 32;
	localparam int OUT_W = 24;
	localparam int ALU_W = 113;

	localparam logic [1:0] ACT_ACC = 2'd0;
	localparam logic [1:0] ACT_REPORT = 2'd1;
	localparam logic [1:0] ACT_CLEAR = 2'd2;
	localparam logic [1:0] ACT_NONE = 2'd3;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	localparam logic REG_CHANNELS = 1'b0;
	localparam logic REG_POLS = 1'b1;

	typedef struct packed {
		logic done;
		logic [OUT_W-1:0] mean;
		logic [OUT_W-1:0] sigma;
	} cmsa_res_t;

endpackage

/* rtl/core/cmsa_ram.sv */
module cmsa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* rtl/core/cmsa_alu.sv */
module cmsa_alu #(
	parameter int W = 113
) (
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	input  logic         sub,
	output logic [W-1:0] res,
	output logic         borrow
);

	logic [W:0] full;

	assign full = {1'b0, a} + {1'b0, (sub ? ~b : b)} + {{W{1'b0}}, sub};
	assign res = full[W-1:0];
	assign borrow = sub & ~full[W];

endmodule

/* rtl/core/cmsa_engine.sv */
module cmsa_engine (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [cmsa_pkg::CNT_W-1:0] cnt_i,
	input  logic [cmsa_pkg::SUM_W-1:0] sum_i,
	input  logic [cmsa_pkg::SQS_W-1:0] sqs_i,
	output cmsa_pkg::cmsa_res_t        res
);

	import cmsa_pkg::*;

	typedef enum logic [8:0] {
		E_IDLE = 9'b000000001,
		E_MDIV = 9'b000000010,
		E_MULC = 9'b000000100,
		E_MULA = 9'b000001000,
		E_MULB = 9'b000010000,
		E_SUB  = 9'b000100000,
		E_VDIV = 9'b001000000,
		E_SQRT = 9'b010000000,
		E_DONE = 9'b100000000
	} eng_state_t;

	eng_state_t state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [SQS_W-1:0] sqs_q;
	logic [SUM_W-1:0] smag_q;
	logic neg_q;
	logic ovf_q;
	logic [111:0] dv_q;
	logic [63:0] rm_q;
	logic [63:0] dd_q;
	logic [95:0] acc_q;
	logic [95:0] a_q;
	logic [63:0] mq_q;
	logic [6:0] step_q;
	logic [OUT_W-1:0] mean_q;
	logic [OUT_W-1:0] rt_q;
	logic [25:0] sr_q;

	logic [ALU_W-1:0] op_a;
	logic [ALU_W-1:0] op_b;
	logic op_sub;
	logic [ALU_W-1:0] alu_res;
	logic borrow;
	logic take;
	logic [64:0] r2;
	logic [63:0] mx;
	logic [27:0] sq_r;
	logic [25:0] trial;
	logic [111:0] dv_nx;
	logic [55:0] q56;
	logic [OUT_W-1:0] mean_nx;
	logic [SUM_W-1:0] smag_in;
	logic [55:0] num_in;
	logic last;

	cmsa_alu #(.W(ALU_W)) u_alu (
		.a(op_a),
		.b(op_b),
		.sub(op_sub),
		.res(alu_res),
		.borrow(borrow)
	);

	assign r2 = {rm_q, dv_q[111]};
	assign sq_r = {sr_q, dv_q[47:46]};
	assign trial = {rt_q, 2'b01};
	assign take = ~borrow;
	assign dv_nx = {dv_q[110:0], take};
	assign q56 = dv_nx[55:0];
	assign last = (step_q == 7'd1);
	assign smag_in = sum_i[SUM_W-1] ? (~sum_i + 1'b1) : sum_i;
	assign num_in = {smag_in, 8'b0} + 56'(cnt_i[CNT_W-1:1]);

	always_comb begin
		unique case (state_q)
			E_MULC: mx = 64'(cnt_q);
			E_MULA: mx = sqs_q;
			default: mx = 64'(smag_q);
		endcase
	end

	always_comb begin
		if (neg_q) begin
			mean_nx = (q56 > 56'd8388608) ? 24'h800000 : (~q56[23:0] + 1'b1);
		end else begin
			mean_nx = (q56 > 56'd8388607) ? 24'h7FFFFF : q56[23:0];
		end
	end

	always_comb begin
		op_a = '0;
		op_b = '0;
		op_sub = 1'b0;
		unique case (state_q)
			E_MDIV, E_VDIV: begin
				op_a = ALU_W'(r2);
				op_b = ALU_W'(dd_q);
				op_sub = 1'b1;
			end
			E_MULC, E_MULA, E_MULB: begin
				op_a = ALU_W'({acc_q[94:0], 1'b0});
				op_b = mq_q[63] ? ALU_W'(mx) : '0;
			end
			E_SUB: begin
				op_a = ALU_W'(a_q);
				op_b = ALU_W'(acc_q);
				op_sub = 1'b1;
			end
			E_SQRT: begin
				op_a = ALU_W'(sq_r);
				op_b = ALU_W'(trial);
				op_sub = 1'b1;
			end
			default: begin
				op_a = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= E_IDLE;
			step_q <= '0;
		end else begin
			unique case (state_q)
				E_IDLE: begin
					if (start) begin
						state_q <= E_MDIV;
						step_q <= 7'd56;
					end
				end
				E_MDIV: begin
					step_q <= last ? 7'd32 : step_q - 1'b1;
					if (last) state_q <= E_MULC;
				end
				E_MULC: begin
					step_q <= last ? 7'd32 : step_q - 1'b1;
					if (last) state_q <= E_MULA;
				end
				E_MULA: begin
					step_q <= last ? 7'd48 : step_q - 1'b1;
					if (last) state_q <= E_MULB;
				end
				E_MULB: begin
					step_q <= last ? 7'd112 : step_q - 1'b1;
					if (last) state_q <= E_SUB;
				end
				E_SUB: begin
					state_q <= E_VDIV;
				end
				E_VDIV: begin
					step_q <= last ? 7'd24 : step_q - 1'b1;
					if (last) state_q <= E_SQRT;
				end
				E_SQRT: begin
					step_q <= step_q - 1'b1;
					if (last) state_q <= E_DONE;
				end
				E_DONE: begin
					state_q <= E_IDLE;
				end
				default: begin
					state_q <= E_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			E_IDLE: begin
				cnt_q <= cnt_i;
				sqs_q <= sqs_i;
				smag_q <= smag_in;
				neg_q <= sum_i[SUM_W-1];
				dv_q <= {num_in, 56'b0};
				rm_q <= '0;
				dd_q <= 64'(cnt_i);
			end
			E_MDIV: begin
				dv_q <= dv_nx;
				rm_q <= take ? alu_res[63:0] : r2[63:0];
				if (last) begin
					mean_q <= mean_nx;
					acc_q <= '0;
					mq_q <= {cnt_q, 32'b0};
				end
			end
			E_MULC, E_MULA, E_MULB: begin
				if (!last) begin
					acc_q <= alu_res[95:0];
					mq_q <= {mq_q[62:0], 1'b0};
				end else begin
					unique case (state_q)
						E_MULC: begin
							dd_q <= alu_res[63:0];
							acc_q <= '0;
							mq_q <= {cnt_q, 32'b0};
						end
						E_MULA: begin
							a_q <= alu_res[95:0];
							acc_q <= '0;
							mq_q <= {smag_q, 16'b0};
						end
						default: begin
							acc_q <= alu_res[95:0];
						end
					endcase
				end
			end
			E_SUB: begin
				dv_q <= borrow ? '0 : {alu_res[95:0], 16'b0};
				rm_q <= '0;
			end
			E_VDIV: begin
				dv_q <= dv_nx;
				rm_q <= take ? alu_res[63:0] : r2[63:0];
				if (last) begin
					ovf_q <= |dv_nx[111:48];
					sr_q <= '0;
					rt_q <= '0;
				end
			end
			E_SQRT: begin
				dv_q <= {dv_q[109:0], 2'b00};
				sr_q <= take ? alu_res[25:0] : sq_r[25:0];
				rt_q <= {rt_q[22:0], take};
			end
			default: begin
				neg_q <= neg_q;
			end
		endcase
	end

	assign res.done = (state_q == E_DONE);
	assign res.mean = mean_q;
	assign res.sigma = ovf_q ? {OUT_W{1'b1}} : rt_q;

endmodule

/* rtl/core/channel_mean_sigma_accumulator_core.sv */
// channel  direction  handshake                 payload
// cfg      in         cfg_we                    cfg_index, cfg_data
// in       in         in_valid / in_ready       action, channel, polarization, sample
// out      out        out_valid / out_ready     mean_value, sigma_value, sample_count, status
//
// accumulate: memory read, then read-modify-write of the entry
// report: runs in the shared add/subtract unit (two restoring divisions,
//   three shift-add multiplies, a 24-step square root)
// clear and reset: a sweep over all MAX_CHANNELS*MAX_POLS entries zeroing the stores, in_ready low
// a finished report waits in a holding register; in_ready stays low until it is loaded into the output register
module channel_mean_sigma_accumulator_core #(
	parameter int MAX_CHANNELS = cmsa_pkg::MAX_CHANNELS_DEF,
	parameter int MAX_POLS = cmsa_pkg::MAX_POLS_DEF,
	parameter int SAMPLE_BITS = cmsa_pkg::SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [10:0]                   cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    action,
	input  logic [9:0]                    channel,
	input  logic [1:0]                    polarization,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [cmsa_pkg::OUT_W-1:0] mean_value,
	output logic [cmsa_pkg::OUT_W-1:0]    sigma_value,
	output logic [cmsa_pkg::CNT_W-1:0]    sample_count,
	output logic [1:0]                    status
);

	import cmsa_pkg::*;

	localparam int ENTRIES = MAX_CHANNELS * MAX_POLS;
	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	typedef enum logic [5:0] {
		S_CLR  = 6'b000001,
		S_IDLE = 6'b000010,
		S_ACC  = 6'b000100,
		S_RD   = 6'b001000,
		S_RUN  = 6'b010000,
		S_OUT  = 6'b100000
	} state_t;

	state_t state_q;
	logic [10:0] chan_q;
	logic [2:0] pol_q;
	logic [IW-1:0] idx_q;
	logic [IW-1:0] clr_q;
	logic signed [SAMPLE_BITS-1:0] sample_q;
	logic [2*SAMPLE_BITS-1:0] sqr_q;
	logic [OUT_W-1:0] pmean_q;
	logic [OUT_W-1:0] psigma_q;
	logic [CNT_W-1:0] pcnt_q;
	logic [1:0] pstat_q;
	logic out_valid_q;

	logic in_fire;
	logic idx_ok;
	logic [IW-1:0] in_idx;
	logic [IW-1:0] raddr;
	logic [IW-1:0] waddr;
	logic we;
	logic [SUM_W-1:0] sum_rd, sum_wr;
	logic [SQS_W-1:0] sqs_rd, sqs_wr;
	logic [CNT_W-1:0] cnt_rd, cnt_wr;
	logic [SUM_W:0] sum49;
	logic [SQS_W:0] sqs65;
	logic [SAMPLE_BITS-1:0] mag;
	logic eng_start;
	logic out_load;
	cmsa_res_t eng_res;

	assign in_ready = (state_q == S_IDLE);
	assign in_fire = in_valid & in_ready;
	assign idx_ok = ({1'b0, channel} < chan_q) && (32'(channel) < 32'(MAX_CHANNELS))
		&& ({1'b0, polarization} < pol_q) && (32'(polarization) < 32'(MAX_POLS));
	assign in_idx = IW'(32'(channel) * 32'(MAX_POLS) + 32'(polarization));
	assign raddr = in_fire ? in_idx : idx_q;
	assign mag = sample[SAMPLE_BITS-1] ? (~sample + 1'b1) : sample;
	assign out_load = (state_q == S_OUT) && (!out_valid_q || out_ready);

	assign sum49 = {sum_rd[SUM_W-1], sum_rd} + (SUM_W+1)'(sample_q);
	assign sqs65 = {1'b0, sqs_rd} + (SQS_W+1)'(sqr_q);

	always_comb begin
		if (state_q == S_CLR) begin
			we = 1'b1;
			waddr = clr_q;
			sum_wr = '0;
			sqs_wr = '0;
			cnt_wr = '0;
		end else begin
			we = (state_q == S_ACC);
			waddr = idx_q;
			if (sum49[SUM_W] != sum49[SUM_W-1]) begin
				sum_wr = sum49[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
			end else begin
				sum_wr = sum49[SUM_W-1:0];
			end
			sqs_wr = sqs65[SQS_W] ? {SQS_W{1'b1}} : sqs65[SQS_W-1:0];
			cnt_wr = (&cnt_rd) ? cnt_rd : cnt_rd + 1'b1;
		end
	end

	cmsa_ram #(.WIDTH(SUM_W), .DEPTH(ENTRIES)) u_sum_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(sum_wr), .raddr(raddr), .rdata(sum_rd)
	);

	cmsa_ram #(.WIDTH(SQS_W), .DEPTH(ENTRIES)) u_sqs_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(sqs_wr), .raddr(raddr), .rdata(sqs_rd)
	);

	cmsa_ram #(.WIDTH(CNT_W), .DEPTH(ENTRIES)) u_cnt_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(cnt_wr), .raddr(raddr), .rdata(cnt_rd)
	);

	assign eng_start = (state_q == S_RD) && (cnt_rd != '0);

	cmsa_engine u_engine (
		.clk(clk),
		.arst_n(arst_n),
		.start(eng_start),
		.cnt_i(cnt_rd),
		.sum_i(sum_rd),
		.sqs_i(sqs_rd),
		.res(eng_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_q <= 11'd1024;
			pol_q <= 3'd2;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CHANNELS: chan_q <= cfg_data;
				REG_POLS: pol_q <= cfg_data[2:0];
				default: chan_q <= chan_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLR: begin
					if (clr_q == IW'(ENTRIES - 1)) begin
						clr_q <= '0;
						state_q <= S_IDLE;
					end else begin
						clr_q <= clr_q + 1'b1;
					end
				end
				S_IDLE: begin
					if (in_fire) begin
						priority if (action == ACT_CLEAR) begin
							state_q <= S_CLR;
						end else if (action == ACT_ACC && idx_ok) begin
							state_q <= S_ACC;
						end else if (action == ACT_REPORT) begin
							state_q <= idx_ok ? S_RD : S_OUT;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_ACC: begin
					state_q <= S_IDLE;
				end
				S_RD: begin
					state_q <= (cnt_rd == '0) ? S_OUT : S_RUN;
				end
				S_RUN: begin
					if (eng_res.done) state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_load) state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			idx_q <= in_idx;
			sample_q <= sample;
			sqr_q <= mag * mag;
			pmean_q <= '0;
			psigma_q <= '0;
			pcnt_q <= '0;
			pstat_q <= ST_RANGE;
		end
		if (state_q == S_RD && cnt_rd == '0) begin
			pstat_q <= ST_EMPTY;
		end
		if (state_q == S_RUN && eng_res.done) begin
			pmean_q <= eng_res.mean;
			psigma_q <= eng_res.sigma;
			pcnt_q <= cnt_rd;
			pstat_q <= ST_OK;
		end
		if (out_load) begin
			mean_value <= pmean_q;
			sigma_value <= psigma_q;
			sample_count <= pcnt_q;
			status <= pstat_q;
		end
	end

	assign out_valid = out_valid_q;

	a_busy_after_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && ((action == ACT_ACC && idx_ok) || action == ACT_REPORT
		|| action == ACT_CLEAR)
		|=> !in_ready)
		else $error("ready held high after an item");

	a_done_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		eng_res.done |-> state_q == S_RUN)
		else $error("engine result outside a report");

	a_out_from_out_state: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == S_OUT))
		else $error("result shown without a finished report");

endmodule
